### design/frc_pkg.sv
// Shared constants, types, symbol decoder and count clamp for residue composition.
`default_nettype none
package frc_pkg;

   // Counter and field widths
   localparam int COUNT_BITS  = 32;
   localparam int NUM_SYMBOLS = 26;
   localparam int SYM_W       = 5;
   localparam int OUT_CNT_W   = 32;
   localparam int BYTE_W      = 8;
   localparam int RSP_DATA_W  = ((SYM_W + OUT_CNT_W + 7) / 8) * 8;
   localparam int RSP_PAD_W   = RSP_DATA_W - SYM_W - OUT_CNT_W;

   localparam logic [SYM_W-1:0] LAST_SYM = SYM_W'(NUM_SYMBOLS - 1);
   localparam logic [SYM_W-1:0] DASH_SYM = SYM_W'(24);
   localparam logic [SYM_W-1:0] DOT_SYM  = SYM_W'(25);

   // Byte codes
   localparam logic [BYTE_W-1:0] CH_HEADER  = 8'h3E;  // '>'
   localparam logic [BYTE_W-1:0] CH_NEWLINE = 8'h0A;
   localparam logic [BYTE_W-1:0] CH_STOP_LO = 8'h00;
   localparam logic [BYTE_W-1:0] CH_STOP_HI = 8'hFF;  // (char) EOF
   localparam logic [BYTE_W-1:0] CH_DASH    = 8'h2D;
   localparam logic [BYTE_W-1:0] CH_DOT     = 8'h2E;
   localparam logic [BYTE_W-1:0] CH_UPPER_A = 8'h41;
   localparam logic [BYTE_W-1:0] CH_UPPER_Z = 8'h5A;
   localparam logic [BYTE_W-1:0] CH_LOWER_A = 8'h61;
   localparam logic [BYTE_W-1:0] CH_LOWER_Z = 8'h7A;
   localparam logic [BYTE_W-1:0] CASE_DIFF  = 8'h20;
   localparam logic [BYTE_W-1:0] LETTER_J   = 8'd9;
   localparam logic [BYTE_W-1:0] LETTER_O   = 8'd14;

   // Decoded symbol of one byte
   typedef struct packed {
      logic             hit;
      logic [SYM_W-1:0] slot;
   } sym_type;

   // Parser to counter chain control
   typedef struct packed {
      logic             count_en;
      logic [SYM_W-1:0] slot;
      logic             flush;
   } parse_ctl_type;

   // Map a byte to its symbol slot
   function automatic sym_type decode_symbol(input logic [BYTE_W-1:0] b);
      logic [BYTE_W-1:0] folded;
      logic [BYTE_W-1:0] letter;
      sym_type           res;
      res.hit  = 1'b0;
      res.slot = '0;
      folded   = b;
      if (b >= CH_LOWER_A && b <= CH_LOWER_Z) begin
         folded = b - CASE_DIFF;
      end
      letter = folded - CH_UPPER_A;
      if (b == CH_DASH) begin
         res.hit  = 1'b1;
         res.slot = DASH_SYM;
      end else if (b == CH_DOT) begin
         res.hit  = 1'b1;
         res.slot = DOT_SYM;
      end else if (folded >= CH_UPPER_A && folded <= CH_UPPER_Z) begin
         if (letter < LETTER_J) begin
            res.hit  = 1'b1;
            res.slot = SYM_W'(letter);
         end else if (letter == LETTER_J || letter == LETTER_O) begin
            res.hit = 1'b0;
         end else if (letter < LETTER_O) begin
            res.hit  = 1'b1;
            res.slot = SYM_W'(letter - 8'd1);
         end else begin
            res.hit  = 1'b1;
            res.slot = SYM_W'(letter - 8'd2);
         end
      end
      return res;
   endfunction

   // Clamp a counter value to the output count width
   function automatic logic [OUT_CNT_W-1:0] clamp_count(input logic [COUNT_BITS-1:0] c);
      logic [63:0] wide;
      wide = 64'(c);
      return (wide > 64'(32'hFFFF_FFFF)) ? {OUT_CNT_W{1'b1}} : wide[OUT_CNT_W-1:0];
   endfunction

endpackage
`default_nettype wire

### design/fasta_residue_composition_core.sv
// Top level of the FASTA residue composition counter: parser, counter chain, result port.
//
// Input channel (req_): one byte of FASTA text per item in req_tdata; req_tlast marks
// end of stream, which flushes the open record and returns the block to its start state.
// Result channel (rsp_): 26 items per record, symbol index 0..25 in order, each with its
// count; rsp_tlast is high on the last item (period) of a record.
// Throughput: one input byte per cycle while no record is flushing. A byte that closes a
// record (a header line start or end of stream) starts a flush: its first result item is
// offered in the next cycle, and the 26 items leave one per cycle as the counter chain
// shifts toward the output. req_tready stays low until the last item is taken; an
// rsp_tready low holds the current item and the chain.
// Reset clears all counters and line state; no results are pending after reset.
`default_nettype none
module fasta_residue_composition_core (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   input  wire logic [7:0]                      req_tdata,   // [7:0] byte_value
   input  wire logic                            req_tlast,   // end_of_stream
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   output logic      [frc_pkg::RSP_DATA_W-1:0]  rsp_tdata,   // [4:0] symbol_index,
                                                             // [36:5] symbol_count, rest 0
   output logic                                 rsp_tlast    // last_of_record
);

   logic                          req_accept;
   logic                          rsp_accept;
   frc_pkg::parse_ctl_type        ctl;
   logic                          flush_ff, flush_in;
   logic [frc_pkg::SYM_W-1:0]     idx_ff,   idx_in;
   logic [frc_pkg::COUNT_BITS-1:0] counts [frc_pkg::NUM_SYMBOLS];
   logic [frc_pkg::COUNT_BITS-1:0] chain_in [frc_pkg::NUM_SYMBOLS];
   logic                          shift;

   assign req_tready = !flush_ff;
   assign req_accept = req_tvalid & req_tready;
   assign rsp_accept = rsp_tvalid & rsp_tready;
   assign shift      = rsp_accept;

   frc_parser u_parser (
      .clock         (clock),
      .reset         (reset),
      .accept        (req_accept),
      .byte_value    (req_tdata),
      .end_of_stream (req_tlast),
      .ctl           (ctl)
   );

   // Build the counter chain; the far end shifts in zero
   for (genvar k = 0; k < frc_pkg::NUM_SYMBOLS; k++) begin : g_cell
      if (k == frc_pkg::NUM_SYMBOLS - 1) begin : g_end
         assign chain_in[k] = '0;
      end else begin : g_mid
         assign chain_in[k] = counts[k+1];
      end
      frc_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .inc      (ctl.count_en && ctl.slot == frc_pkg::SYM_W'(k)),
         .shift    (shift),
         .shift_in (chain_in[k]),
         .count    (counts[k])
      );
   end

   // Advance the flush index, drop the flush after the last item
   always_comb begin
      flush_in = flush_ff;
      idx_in   = idx_ff;
      if (rsp_accept) begin
         if (idx_ff == frc_pkg::LAST_SYM) begin
            flush_in = 1'b0;
            idx_in   = '0;
         end else begin
            idx_in = idx_ff + 1'b1;
         end
      end else if (ctl.flush) begin
         flush_in = 1'b1;
         idx_in   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flush_ff <= 1'b0;
         idx_ff   <= '0;
      end else begin
         flush_ff <= flush_in;
         idx_ff   <= idx_in;
      end
   end

   // Present the head of the chain
   assign rsp_tvalid = flush_ff;
   assign rsp_tdata  = {{frc_pkg::RSP_PAD_W{1'b0}}, frc_pkg::clamp_count(counts[0]), idx_ff};
   assign rsp_tlast  = (idx_ff == frc_pkg::LAST_SYM);

endmodule
`default_nettype wire

### design/frc_parser.sv
// Line and record tracker: decides what each accepted byte counts and when to flush.
`default_nettype none
module frc_parser (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        accept,
   input  wire logic [frc_pkg::BYTE_W-1:0]  byte_value,
   input  wire logic                        end_of_stream,
   output frc_pkg::parse_ctl_type           ctl
);

   logic at_line_start_ff, at_line_start_in;
   logic in_header_ff,     in_header_in;
   logic stopped_ff,       stopped_in;
   logic record_open_ff,   record_open_in;
   frc_pkg::sym_type sym;
   logic count_en;
   logic flush;

   assign sym = frc_pkg::decode_symbol(byte_value);

   // Work out next line state, count enable and flush for this byte
   always_comb begin
      at_line_start_in = at_line_start_ff;
      in_header_in     = in_header_ff;
      stopped_in       = stopped_ff;
      record_open_in   = record_open_ff;
      count_en         = 1'b0;
      flush            = 1'b0;
      if (end_of_stream) begin
         flush            = record_open_ff;
         at_line_start_in = 1'b1;
         in_header_in     = 1'b0;
         stopped_in       = 1'b0;
         record_open_in   = 1'b0;
      end else begin
         // open a header at a line start
         if (at_line_start_ff) begin
            at_line_start_in = 1'b0;
            if (!record_open_ff || byte_value == frc_pkg::CH_HEADER) begin
               flush          = record_open_ff;
               record_open_in = 1'b1;
               in_header_in   = 1'b1;
            end
         end
         if (byte_value == frc_pkg::CH_NEWLINE) begin
            at_line_start_in = 1'b1;
            in_header_in     = 1'b0;
            stopped_in       = 1'b0;
         end else if (in_header_in || stopped_ff) begin
            count_en = 1'b0;
         end else if (byte_value == frc_pkg::CH_STOP_LO ||
                      byte_value == frc_pkg::CH_STOP_HI) begin
            stopped_in = 1'b1;
         end else begin
            count_en = sym.hit;
         end
      end
   end

   // Hold line state between accepted bytes
   always_ff @(posedge clock) begin
      if (reset) begin
         at_line_start_ff <= 1'b1;
         in_header_ff     <= 1'b0;
         stopped_ff       <= 1'b0;
         record_open_ff   <= 1'b0;
      end else if (accept) begin
         at_line_start_ff <= at_line_start_in;
         in_header_ff     <= in_header_in;
         stopped_ff       <= stopped_in;
         record_open_ff   <= record_open_in;
      end
   end

   assign ctl.count_en = accept & count_en;
   assign ctl.slot     = sym.slot;
   assign ctl.flush    = accept & flush;

endmodule
`default_nettype wire

### design/frc_cell.sv
// One counter cell of the chain: counts its symbol and shifts its value to the neighbor.
`default_nettype none
module frc_cell (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            inc,
   input  wire logic                            shift,
   input  wire logic [frc_pkg::COUNT_BITS-1:0]  shift_in,
   output logic      [frc_pkg::COUNT_BITS-1:0]  count
);

   logic [frc_pkg::COUNT_BITS-1:0] count_ff, count_in;

   // Take the neighbor's value on shift, else count up and saturate
   always_comb begin
      count_in = count_ff;
      if (shift) begin
         count_in = shift_in;
      end else if (inc && count_ff != {frc_pkg::COUNT_BITS{1'b1}}) begin
         count_in = count_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   assign count = count_ff;

endmodule
`default_nettype wire

### sim/fasta_residue_composition_checker.sv
// Channel monitor, residue count predictor and result comparator for the composition core.
module fasta_residue_composition_checker (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_tvalid,
   input  wire logic                           req_tready,
   input  wire logic [7:0]                     req_tdata,   // [7:0] byte_value
   input  wire logic                           req_tlast,   // end_of_stream
   input  wire logic                           rsp_tvalid,
   input  wire logic                           rsp_tready,
   input  wire logic [frc_pkg::RSP_DATA_W-1:0] rsp_tdata,   // [4:0] symbol_index,
                                                            // [36:5] symbol_count
   input  wire logic                           rsp_tlast,   // last_of_record
   output int                                  fail_count,
   output int                                  pending,
   output int                                  results_seen,
   output int                                  records_seen
);

   // Counted symbols in slot order, first slot in the top byte
   localparam logic [8*frc_pkg::NUM_SYMBOLS-1:0] SYMBOL_ORDER = "ABCDEFGHIKLMNPQRSTUVWXYZ-.";
   localparam longint unsigned COUNT_CEILING = (64'd1 << frc_pkg::COUNT_BITS) - 64'd1;

   typedef struct packed {
      logic [frc_pkg::SYM_W-1:0]     sym;
      logic [frc_pkg::OUT_CNT_W-1:0] cnt;
      logic                          last;
   } residue_count_type;

   residue_count_type expected_counts[$];
   longint unsigned   tally[frc_pkg::NUM_SYMBOLS];
   bit                line_start;
   bit                header_line;
   bit                line_stopped;
   bit                record_open;
   int                errors;
   int                n_results;
   int                n_records;

   // Slot of a byte after case folding, -1 when not counted
   function automatic int symbol_of(input logic [7:0] b);
      logic [7:0] folded;
      folded = b;
      if (b >= frc_pkg::CH_LOWER_A && b <= frc_pkg::CH_LOWER_Z) begin
         folded = b - frc_pkg::CASE_DIFF;
      end
      for (int k = 0; k < frc_pkg::NUM_SYMBOLS; k++) begin
         if (folded == SYMBOL_ORDER[8*(frc_pkg::NUM_SYMBOLS-1-k) +: 8]) begin
            return k;
         end
      end
      return -1;
   endfunction

   // Return to the start-of-stream state
   task automatic restart_stream();
      foreach (tally[k]) tally[k] = 0;
      line_start   = 1'b1;
      header_line  = 1'b0;
      line_stopped = 1'b0;
      record_open  = 1'b0;
   endtask

   // Queue the 26 counts of the open record and clear them
   task automatic close_record();
      residue_count_type item;
      for (int k = 0; k < frc_pkg::NUM_SYMBOLS; k++) begin
         item.sym  = frc_pkg::SYM_W'(k);
         item.cnt  = (tally[k] > 64'hFFFF_FFFF) ? '1 : tally[k][frc_pkg::OUT_CNT_W-1:0];
         item.last = (k == frc_pkg::NUM_SYMBOLS - 1);
         expected_counts.push_back(item);
         tally[k] = 0;
      end
   endtask

   // Advance the parser state by one accepted byte
   task automatic predict_byte(input logic [7:0] b, input logic eos);
      int slot;
      if (eos) begin
         if (record_open) close_record();
         restart_stream();
         return;
      end
      if (line_start) begin
         line_start = 1'b0;
         if (!record_open || b == frc_pkg::CH_HEADER) begin
            if (record_open) close_record();
            record_open = 1'b1;
            header_line = 1'b1;
         end
      end
      if (b == frc_pkg::CH_NEWLINE) begin
         line_start   = 1'b1;
         header_line  = 1'b0;
         line_stopped = 1'b0;
      end else if (!header_line && !line_stopped) begin
         if (b == frc_pkg::CH_STOP_LO || b == frc_pkg::CH_STOP_HI) begin
            line_stopped = 1'b1;
         end else begin
            slot = symbol_of(b);
            if (slot >= 0 && tally[slot] < COUNT_CEILING) tally[slot]++;
         end
      end
   endtask

   // Compare one accepted count item with the oldest expectation
   task automatic check_count(input logic [frc_pkg::RSP_DATA_W-1:0] data, input logic last);
      residue_count_type             want;
      logic [frc_pkg::SYM_W-1:0]     got_sym;
      logic [frc_pkg::OUT_CNT_W-1:0] got_cnt;
      got_sym = data[frc_pkg::SYM_W-1:0];
      got_cnt = data[frc_pkg::SYM_W +: frc_pkg::OUT_CNT_W];
      n_results++;
      if (last) n_records++;
      if (expected_counts.size() == 0) begin
         $display("%0t: unexpected count item: index %0d count %0d last %0b",
                  $time, got_sym, got_cnt, last);
         errors++;
         return;
      end
      want = expected_counts.pop_front();
      if (got_sym !== want.sym) begin
         $display("%0t: symbol index expected %0d got %0d", $time, want.sym, got_sym);
         errors++;
      end
      if (got_cnt !== want.cnt) begin
         $display("%0t: count of symbol %0d expected %0d got %0d",
                  $time, want.sym, want.cnt, got_cnt);
         errors++;
      end
      if (last !== want.last) begin
         $display("%0t: last flag of symbol %0d expected %0b got %0b",
                  $time, want.sym, want.last, last);
         errors++;
      end
      if (data[frc_pkg::RSP_DATA_W-1:frc_pkg::SYM_W+frc_pkg::OUT_CNT_W] !== '0) begin
         $display("%0t: padding of symbol %0d expected 0 got %0h",
                  $time, want.sym,
                  data[frc_pkg::RSP_DATA_W-1:frc_pkg::SYM_W+frc_pkg::OUT_CNT_W]);
         errors++;
      end
   endtask

   // Watch both channels; publish the totals as registered outputs
   always @(posedge clock) begin
      if (reset) begin
         expected_counts.delete();
         restart_stream();
         errors    = 0;
         n_results = 0;
         n_records = 0;
      end else begin
         if (req_tvalid && req_tready) predict_byte(req_tdata, req_tlast);
         if (rsp_tvalid && rsp_tready) check_count(rsp_tdata, rsp_tlast);
      end
      fail_count   <= errors;
      pending      <= expected_counts.size();
      results_seen <= n_results;
      records_seen <= n_records;
   end

endmodule

### sim/fasta_residue_composition_core_tb.sv
// Testbench top for the composition core: clock, reset, byte stimulus, receiver and verdict.
module fasta_residue_composition_core_tb;

   localparam int ITEM_TARGET = 300;
   localparam int LONG_HOLD   = 300;
   localparam int DRAIN_WAIT  = 40;

   logic                           clock       = 1'b0;
   logic                           reset       = 1'b1;
   logic                           req_tvalid  = 1'b0;
   logic                           req_tready;
   logic [7:0]                     req_tdata   = '0;
   logic                           req_tlast   = 1'b0;
   logic                           rsp_tvalid;
   logic                           rsp_tready  = 1'b0;
   logic [frc_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic                           rsp_tlast;

   int fail_count;
   int pending;
   int results_seen;
   int records_seen;
   int bytes_sent    = 0;
   int streams_sent  = 0;
   int hold_requests = 0;
   bit hold_active   = 1'b0;
   bit no_idle       = 1'b0;

   always #5 clock = ~clock;

   fasta_residue_composition_core DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   fasta_residue_composition_checker u_checker (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tdata    (req_tdata),
      .req_tlast    (req_tlast),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .rsp_tlast    (rsp_tlast),
      .fail_count   (fail_count),
      .pending      (pending),
      .results_seen (results_seen),
      .records_seen (records_seen)
   );

   // Gap length: mostly none or short, a few long
   function automatic int idle_len();
      int r;
      if (no_idle) return 0;
      r = $urandom_range(0, 99);
      if (r < 65) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Offer one byte after a random gap and hold it until taken
   task automatic put_byte(input logic [7:0] b, input logic eos);
      int gap;
      gap = idle_len();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= eos;
      do @(posedge clock); while (!req_tready);
      bytes_sent++;
   endtask

   // Hold off until every queued count item has been taken
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending != 0);
   endtask

   // Sequence byte: mostly residues, some gaps, stop bytes and raw noise
   function automatic logic [7:0] residue_byte();
      int r;
      logic [7:0] b;
      r = $urandom_range(0, 99);
      if (r < 70) begin
         b = frc_pkg::CH_UPPER_A + 8'($urandom_range(0, 25));
         if ($urandom_range(0, 1)) b = b + frc_pkg::CASE_DIFF;
      end else if (r < 80) begin
         b = $urandom_range(0, 1) ? frc_pkg::CH_DASH : frc_pkg::CH_DOT;
      end else if (r < 85) begin
         b = $urandom_range(0, 1) ? frc_pkg::CH_STOP_HI : frc_pkg::CH_STOP_LO;
      end else begin
         b = 8'($urandom_range(0, 255));
      end
      return b;
   endfunction

   // Header line; a newline lead makes an empty header
   task automatic send_header(input logic [7:0] lead);
      logic [7:0] b;
      put_byte(lead, 1'b0);
      if (lead != frc_pkg::CH_NEWLINE) begin
         repeat ($urandom_range(0, 6)) begin
            b = 8'($urandom_range(0, 255));
            if (b == frc_pkg::CH_NEWLINE) b = frc_pkg::CH_DOT;
            put_byte(b, 1'b0);
         end
         put_byte(frc_pkg::CH_NEWLINE, 1'b0);
      end
   endtask

   // Well-formed stream: a few records with random content, then end of stream
   task automatic send_stream();
      int n_rec;
      int n_lines;
      bit open_tail;
      n_rec     = $urandom_range(1, 4);
      open_tail = ($urandom_range(0, 2) == 0);
      for (int r = 0; r < n_rec; r++) begin
         if (r == 0 && $urandom_range(0, 4) == 0) send_header(8'($urandom_range(0, 255)));
         else send_header(frc_pkg::CH_HEADER);
         n_lines = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 3);
         for (int l = 0; l < n_lines; l++) begin
            repeat ($urandom_range(1, 16)) put_byte(residue_byte(), 1'b0);
            if (!(open_tail && r == n_rec - 1 && l == n_lines - 1)) begin
               put_byte(frc_pkg::CH_NEWLINE, 1'b0);
            end
         end
      end
      put_byte(8'($urandom_range(0, 255)), 1'b1);
      streams_sent++;
   endtask

   // Raw bytes with an occasional end of stream, closed by one
   task automatic send_noise();
      repeat ($urandom_range(8, 30)) put_byte(8'($urandom_range(0, 255)),
                                             $urandom_range(0, 19) == 0);
      put_byte(8'($urandom_range(0, 255)), 1'b1);
      streams_sent++;
   endtask

   // Hold reset at start, then release it
   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
   end

   // Receiver: random ready with bursts, plus a counted long hold on request
   initial begin : rsp_side
      int gap;
      int holds_done;
      holds_done = 0;
      @(posedge clock);
      forever begin
         if (hold_requests != holds_done) begin
            holds_done++;
            rsp_tready  <= 1'b0;
            hold_active <= 1'b1;
            repeat (LONG_HOLD) @(posedge clock);
            hold_active <= 1'b0;
         end else begin
            gap = idle_len();
            if (gap > 0) begin
               rsp_tready <= 1'b0;
               repeat (gap) @(posedge clock);
            end
            rsp_tready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end
      end
   end

   // Stimulus and verdict
   initial begin : req_side
      bit mid_pause_done;
      mid_pause_done = 1'b0;
      do @(posedge clock); while (reset);

      // End of stream with nothing open emits nothing
      put_byte(8'h00, 1'b1);
      // Empty first line opens a record; a header right after it closes it with zeros
      put_byte(frc_pkg::CH_NEWLINE, 1'b0);
      put_byte(frc_pkg::CH_HEADER, 1'b0);
      put_byte("x", 1'b0);
      put_byte(frc_pkg::CH_NEWLINE, 1'b0);
      // Letter extremes, both cases, skipped letters, gaps, high and other bytes
      put_byte("A", 1'b0);
      put_byte("z", 1'b0);
      put_byte("j", 1'b0);
      put_byte("O", 1'b0);
      put_byte(frc_pkg::CH_DASH, 1'b0);
      put_byte(frc_pkg::CH_DOT, 1'b0);
      put_byte(8'h80, 1'b0);
      put_byte("1", 1'b0);
      // Stop bytes silence the rest of their line only
      put_byte(frc_pkg::CH_STOP_LO, 1'b0);
      put_byte("B", 1'b0);
      put_byte(frc_pkg::CH_NEWLINE, 1'b0);
      put_byte("b", 1'b0);
      put_byte(frc_pkg::CH_STOP_HI, 1'b0);
      put_byte("C", 1'b0);
      put_byte(frc_pkg::CH_NEWLINE, 1'b0);
      // Last line without newline, flushed by end of stream with an ignored byte
      put_byte("K", 1'b0);
      put_byte(frc_pkg::CH_STOP_HI, 1'b1);
      // First line of a new stream is a header whatever its first byte
      put_byte("Q", 1'b0);
      put_byte(frc_pkg::CH_NEWLINE, 1'b0);
      put_byte("y", 1'b0);
      put_byte(8'h00, 1'b1);
      wait_drained();

      // Fill the block while the receiver holds off; send without gaps
      hold_requests <= hold_requests + 1;
      no_idle       <= 1'b1;
      do @(posedge clock); while (!hold_active);
      send_stream();

      // Random streams and noise, with stretches without idling
      while (bytes_sent < ITEM_TARGET) begin
         no_idle <= ($urandom_range(0, 4) == 0);
         if ($urandom_range(0, 3) == 0) send_noise();
         else send_stream();
         if (!mid_pause_done && bytes_sent > ITEM_TARGET / 2) begin
            mid_pause_done = 1'b1;
            wait_drained();
         end
      end

      // Drain, then watch for stray items
      wait_drained();
      repeat (DRAIN_WAIT) @(posedge clock);
      if (pending != 0) $display("%0t: %0d count items never arrived", $time, pending);
      $display("run: %0d bytes in %0d streams, %0d count items over %0d records",
               bytes_sent, streams_sent, results_seen, records_seen);
      $display("run: directed header, stop-byte and end-of-stream cases, one long hold");
      if (fail_count == 0 && pending == 0) begin
         $display("fasta_residue_composition_core_tb: clean");
      end else begin
         $display("fasta_residue_composition_core_tb: errors");
      end
      $finish;
   end

   // Timeout
   initial begin
      #20000000;
      $display("%0t: timeout with %0d count items outstanding", $time, pending);
      $display("fasta_residue_composition_core_tb: errors");
      $finish;
   end

endmodule
